[rtl/tpsc_pkg.sv]
// shared types, constants and helpers for the sensor compensation pipeline
package tpsc_pkg;

    localparam int RawW = 20;
    localparam int WordW = 32;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 64;
    // one divider stage per quotient bit
    localparam int DivStages = WordW;

    localparam logic [CfgIdxW-1:0] REG_TEMP_CAL = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LOW = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LAST = 2'd3;

    localparam logic [31:0] K64000 = 32'd64000;
    localparam logic [31:0] K1M = 32'd1048576;
    localparam logic [31:0] K3125 = 32'd3125;
    localparam logic [31:0] K32768 = 32'd32768;
    localparam logic [31:0] K128 = 32'd128;
    localparam logic [31:0] KMSB = 32'h80000000;

    typedef logic [31:0] t_word;

    // calibration words, sign or zero extended to 32 bits
    typedef struct packed {
        t_word t1, t2, t3;
        t_word p1, p2, p3, p4, p5, p6, p7, p8, p9;
    } t_cal;

    // wrapping 32-bit multiply
    function automatic t_word mul32(input t_word a, input t_word b);
        logic [63:0] r;
        r = {32'd0, a} * {32'd0, b};
        return r[31:0];
    endfunction

    // arithmetic shift right
    function automatic t_word asr(input t_word x, input int n);
        return t_word'($signed(x) >>> n);
    endfunction

endpackage

[rtl/tpsc_cfg.sv]
// calibration register file with field extraction
module tpsc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tpsc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [tpsc_pkg::CfgDataW-1:0] i_cfg_data,
    output tpsc_pkg::t_cal                o_cal
);
    import tpsc_pkg::*;

    logic [47:0] r_tcal;
    logic [63:0] r_plow, r_phigh;
    logic [15:0] r_plast;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0;
            r_plow <= '0;
            r_phigh <= '0;
            r_plast <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEMP_CAL:   r_tcal <= i_cfg_data[47:0];
                REG_PRESS_LOW:  r_plow <= i_cfg_data;
                REG_PRESS_HIGH: r_phigh <= i_cfg_data;
                REG_PRESS_LAST: r_plast <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // field extraction
    always_comb begin
        o_cal.t1 = {16'd0, r_tcal[15:0]};
        o_cal.t2 = {{16{r_tcal[31]}}, r_tcal[31:16]};
        o_cal.t3 = {{16{r_tcal[47]}}, r_tcal[47:32]};
        o_cal.p1 = {16'd0, r_plow[15:0]};
        o_cal.p2 = {{16{r_plow[31]}}, r_plow[31:16]};
        o_cal.p3 = {{16{r_plow[47]}}, r_plow[47:32]};
        o_cal.p4 = {{16{r_plow[63]}}, r_plow[63:48]};
        o_cal.p5 = {{16{r_phigh[15]}}, r_phigh[15:0]};
        o_cal.p6 = {{16{r_phigh[31]}}, r_phigh[31:16]};
        o_cal.p7 = {{16{r_phigh[47]}}, r_phigh[47:32]};
        o_cal.p8 = {{16{r_phigh[63]}}, r_phigh[63:48]};
        o_cal.p9 = {{16{r_plast[15]}}, r_plast};
    end
endmodule

[rtl/tpsc_front.sv]
// front stages: temperature, fine temperature, pressure numerator and divisor
module tpsc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [tpsc_pkg::RawW-1:0] i_raw_t,
    input  logic [tpsc_pkg::RawW-1:0] i_raw_p,
    input  tpsc_pkg::t_cal            i_cal,
    output logic                      o_valid,
    output tpsc_pkg::t_word           o_temp,
    output tpsc_pkg::t_word           o_num,
    output tpsc_pkg::t_word           o_div
);
    import tpsc_pkg::*;

    // stage 1: first products
    t_word r1_ma, r1_dd;
    // stage 2
    t_word r2_ma, r2_mb;
    // stage 3: fine
    t_word r3_fine;
    // stage 4
    t_word r4_temp, r4_sq, r4_ap5, r4_ap2;
    // stage 5
    t_word r5_temp, r5_b, r5_a2, r5_sqp3;
    t_word r6_temp, r6_num, r6_div;
    logic [RawW-1:0] r1_p, r2_p, r3_p, r4_p, r5_p;
    logic [5:0] r_vv;

    t_word adc_t, d, q, a4;
    always_comb begin
        adc_t = {12'd0, i_raw_t};
        d = (adc_t >> 4) - i_cal.t1;
        a4 = asr(r3_fine, 1) - K64000;
        q = asr(a4, 2);
    end

    t_word b5, a5, dv;
    always_comb begin
        b5 = mul32(asr(r4_sq, 11), i_cal.p6) + (r4_ap5 << 1);
        b5 = asr(b5, 2) + (i_cal.p4 << 16);
        a5 = asr(r4_ap2, 1);
        dv = asr(asr(r5_sqp3, 3) + r5_a2, 18);
        dv = mul32(K32768 + dv, i_cal.p1);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vv <= '0;
        else if (i_en) r_vv <= {r_vv[4:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ma <= mul32((adc_t >> 3) - (i_cal.t1 << 1), i_cal.t2);
            r1_dd <= mul32(d, d);
            r1_p <= i_raw_p;
            r2_ma <= asr(r1_ma, 11);
            r2_mb <= mul32(asr(r1_dd, 12), i_cal.t3);
            r2_p <= r1_p;
            r3_fine <= r2_ma + asr(r2_mb, 14);
            r3_p <= r2_p;
            r4_temp <= asr(mul32(r3_fine, 32'd5) + K128, 8);
            r4_sq <= mul32(q, q);
            r4_ap5 <= mul32(a4, i_cal.p5);
            r4_ap2 <= mul32(i_cal.p2, a4);
            r4_p <= r3_p;
            r5_temp <= r4_temp;
            r5_b <= b5;
            r5_a2 <= a5;
            r5_sqp3 <= mul32(i_cal.p3, asr(r4_sq, 13));
            r5_p <= r4_p;
            r6_temp <= r5_temp;
            r6_div <= asr(dv, 15);
            r6_num <= mul32((K1M - {12'd0, r5_p}) - asr(r5_b, 12), K3125);
        end
    end

    assign o_valid = r_vv[5];
    assign o_temp = r6_temp;
    assign o_num = r6_num;
    assign o_div = r6_div;
endmodule

[rtl/tpsc_div.sv]
// pipelined restoring divider, one quotient bit per stage
module tpsc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tpsc_pkg::t_word i_dividend,
    input  tpsc_pkg::t_word i_divisor,
    input  tpsc_pkg::t_word i_tag,
    input  logic            i_dbl,
    output logic            o_valid,
    output tpsc_pkg::t_word o_quot,
    output tpsc_pkg::t_word o_tag,
    output logic            o_dbl,
    output logic            o_zero
);
    import tpsc_pkg::*;

    logic [DivStages-1:0] r_v;
    t_word r_rem [DivStages];
    t_word r_q   [DivStages];
    t_word r_d   [DivStages];
    t_word r_tag [DivStages];
    logic  r_dbl [DivStages];

    for (genvar s = 0; s < DivStages; s++) begin : g_st
        logic        v_in, dbl_in;
        t_word       rem_in, q_in, d_in, tag_in;
        logic [32:0] trial, diff;

        // first stage takes the request from the ports
        if (s == 0) begin : g_head
            assign v_in = i_valid;
            assign rem_in = '0;
            assign q_in = i_dividend;
            assign d_in = i_divisor;
            assign tag_in = i_tag;
            assign dbl_in = i_dbl;
        end else begin : g_body
            assign v_in = r_v[s-1];
            assign rem_in = r_rem[s-1];
            assign q_in = r_q[s-1];
            assign d_in = r_d[s-1];
            assign tag_in = r_tag[s-1];
            assign dbl_in = r_dbl[s-1];
        end

        always_comb begin
            trial = {rem_in, q_in[31]};
            diff = trial - {1'b0, d_in};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s] <= 1'b0;
            else if (i_en) r_v[s] <= v_in;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= diff[32] ? trial[31:0] : diff[31:0];
                r_q[s] <= {q_in[30:0], ~diff[32]};
                r_d[s] <= d_in;
                r_tag[s] <= tag_in;
                r_dbl[s] <= dbl_in;
            end
        end
    end

    assign o_valid = r_v[DivStages-1];
    assign o_quot = r_q[DivStages-1];
    assign o_tag = r_tag[DivStages-1];
    assign o_dbl = r_dbl[DivStages-1];
    assign o_zero = (r_d[DivStages-1] == '0);
endmodule

[rtl/tpsc_back.sv]
// back stages: final pressure correction, forced to zero when the divisor was zero
module tpsc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tpsc_pkg::t_word i_quot,
    input  logic            i_dbl,
    input  logic            i_zero,
    input  tpsc_pkg::t_word i_temp,
    input  tpsc_pkg::t_cal  i_cal,
    output logic            o_valid,
    output tpsc_pkg::t_word o_temp,
    output tpsc_pkg::t_word o_press,
    output logic            o_inv
);
    import tpsc_pkg::*;

    logic [2:0] r_v;
    t_word r1_p, r1_t, r2_p, r2_t, r2_sq, r2_b, r3_p, r3_t;
    logic  r1_z, r2_z, r3_z;
    t_word p0, sq8, a3;

    always_comb begin
        p0 = i_dbl ? (i_quot << 1) : i_quot;
        sq8 = mul32(r1_p >> 3, r1_p >> 3);
        a3 = asr(mul32(i_cal.p9, r2_sq >> 13), 12);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[1:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p <= p0; r1_t <= i_temp; r1_z <= i_zero;
            r2_p <= r1_p; r2_t <= r1_t; r2_z <= r1_z;
            r2_sq <= sq8;
            r2_b <= asr(mul32(r1_p >> 2, i_cal.p8), 13);
            r3_t <= r2_t; r3_z <= r2_z;
            r3_p <= r2_z ? '0 : r2_p + asr(a3 + r2_b + i_cal.p7, 4);
        end
    end

    assign o_valid = r_v[2];
    assign o_temp = r3_t;
    assign o_press = r3_p;
    assign o_inv = r3_z;
endmodule

[rtl/temp_pressure_sensor_compensation_top.sv]
// top level of the barometric sensor compensation pipeline
// Usage: present raw temperature and pressure with i_valid; a request is
// taken at each rising edge with i_valid high and o_stall low. Results
// leave on o_valid with temperature, pressure and the invalid flag, taken
// when i_stall is low.
// Throughput: one request per cycle while o_stall is low. Depth: 6 front
// stages, 32 divider stages one quotient bit each, 3 back stages; the
// divider sets the depth.
// Calibration is written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must write it only while idle, the block does not enforce it.
// Reset clears calibration and all valid bits.
// When the receiver stalls, the whole pipeline holds and o_stall follows
// i_stall only while the output holds a result, so bubbles still drain.
module temp_pressure_sensor_compensation_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tpsc_pkg::RawW-1:0]     i_raw_temperature,
    input  logic [tpsc_pkg::RawW-1:0]     i_raw_pressure,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_temperature_centi,
    output logic [31:0]                   o_pressure_pa,
    output logic                          o_pressure_invalid,
    input  logic                          i_cfg_we,
    input  logic [tpsc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [tpsc_pkg::CfgDataW-1:0] i_cfg_data
);
    import tpsc_pkg::*;

    t_cal cal;
    logic en;
    logic f_v, d_v, d_dbl, d_zero;
    t_word f_temp, f_num, f_div, d_q, d_tag, dvd, t_out, p_out;
    logic dbl;

    // global pipeline enable
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    tpsc_cfg u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cal(cal)
    );

    tpsc_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid,
        .i_raw_t(i_raw_temperature), .i_raw_p(i_raw_pressure), .i_cal(cal),
        .o_valid(f_v), .o_temp(f_temp), .o_num(f_num), .o_div(f_div)
    );

    // pick the overflow-safe route of the divide
    always_comb begin
        dbl = (f_num >= KMSB);
        dvd = dbl ? f_num : (f_num << 1);
    end

    tpsc_div u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(f_v), .i_dividend(dvd),
        .i_divisor(f_div), .i_tag(f_temp), .i_dbl(dbl),
        .o_valid(d_v), .o_quot(d_q), .o_tag(d_tag), .o_dbl(d_dbl),
        .o_zero(d_zero)
    );

    tpsc_back u_back (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_v), .i_quot(d_q),
        .i_dbl(d_dbl), .i_zero(d_zero), .i_temp(d_tag), .i_cal(cal),
        .o_valid, .o_temp(t_out), .o_press(p_out), .o_inv(o_pressure_invalid)
    );

    assign o_temperature_centi = $signed(t_out);
    assign o_pressure_pa = p_out;

    // checks
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pressure_pa))
        else $error("result lost under stall");
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure_invalid |-> o_pressure_pa == '0)
        else $error("invalid pressure not zero");
    a_stall_def: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without pending result");
endmodule
